// ===== rtl/core/lei_pkg.sv =====
// Shared types and constants for the line ending indexer.
`default_nettype none

package lei_pkg;

  // Default width of the position, length and ending counters.
  localparam int COUNTER_BITS_DEF = 33;

  // A line may not start beyond 0xFFFFFFFF minus this margin.
  localparam int          OFFSET_MARGIN = 4096;
  localparam logic [63:0] OFF_LIMIT     = 64'hFFFF_FFFF - 64'(OFFSET_MARGIN);

  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_CR = 8'h0D;

  localparam int BOM_W = 3;

  localparam logic [30:0] ROW_MAX = '1;

  // One item yields at most this many results.
  localparam int MAX_RESULTS = 3;
  localparam int PUSH_W      = $clog2(MAX_RESULTS + 1);
  localparam int RQ_DEPTH    = 4;

  typedef enum logic [1:0] {
    END_LF   = 2'd0,
    END_CRLF = 2'd1,
    END_CR   = 2'd2,
    END_NONE = 2'd3
  } line_end_t;

  typedef enum logic [1:0] {
    KIND_LINE    = 2'd0,
    KIND_SUMMARY = 2'd1,
    KIND_ERROR   = 2'd2
  } result_kind_t;

  typedef struct packed {
    result_kind_t result_kind;
    logic [31:0]  line_offset;
    logic [32:0]  line_length;
    line_end_t    line_end;
    logic [30:0]  row_count;
    logic [32:0]  max_length;
    logic [32:0]  total_bytes;
    line_end_t    dominant_end;
    logic         last_result;
  } result_t;

  typedef struct packed {
    logic not_empty;
    logic room;
  } rq_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/line_ending_indexer.sv =====
// Top level of the line ending indexer: input register, scanner, result queue, APB register.
// An accepted byte waits in the input register until the scanner can push its results.
// Throughput: one byte per cycle while the queue has room; results leave one a cycle
// unless out_stall is high, so a byte giving two or three results can hold up the input.
// Reset (rst_n low, synchronous) empties the pipeline and queue and clears all file state.
`default_nettype none

module line_ending_indexer #(
  parameter int COUNTER_BITS = lei_pkg::COUNTER_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  // Configuration port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready,

  // Byte input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_has_byte,
  input  wire logic        in_last_item,

  // Result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_result_kind,
  output logic [31:0]      out_line_offset,
  output logic [32:0]      out_line_length,
  output logic [1:0]       out_line_end,
  output logic [30:0]      out_row_count,
  output logic [32:0]      out_max_length,
  output logic [32:0]      out_total_bytes,
  output logic [1:0]       out_dominant_end,
  output logic             out_last_result
);

  localparam logic [2:0] ADDR_BOM = 3'd0;

  // The byte-order-mark length register. Software must write it only while the
  // block is idle; the block does not enforce this. The scanner reads it directly.
  logic [lei_pkg::BOM_W-1:0] bom_r;
  logic                      cfg_wr;

  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == ADDR_BOM) ? 32'(bom_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bom_r <= '0;
    end else if (cfg_wr && (cfg_paddr == ADDR_BOM)) begin
      bom_r <= cfg_pwdata[lei_pkg::BOM_W-1:0];
    end
  end

  // Input register. The held item moves into the scanner when the result
  // queue is sure to have room for all results it may cause (three at most),
  // counting the result leaving the queue in this same cycle. A new
  // transaction is taken whenever the register is empty or is being drained.
  logic                in_vld_r;
  logic                in_vld_nxt;
  logic [7:0]          data_r;
  logic                has_r;
  logic                last_r;
  logic                in_take;
  logic                fire;
  logic                pop;
  lei_pkg::rq_status_t rq_stat;

  assign fire     = in_vld_r && rq_stat.room;
  assign in_stall = in_vld_r && !rq_stat.room;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    if (in_take) begin
      in_vld_nxt = 1'b1;
    end else if (fire) begin
      in_vld_nxt = 1'b0;
    end else begin
      in_vld_nxt = in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      data_r <= in_data_byte;
      has_r  <= in_has_byte;
      last_r <= in_last_item;
    end
  end

  // The scanner closes lines, keeps the per-file statistics and formats up
  // to three results (line, line, summary or error) for the item it fires on.
  logic [lei_pkg::PUSH_W-1:0]                 push_cnt;
  lei_pkg::result_t [lei_pkg::MAX_RESULTS-1:0] push_res;

  lei_scan #(
    .CW (COUNTER_BITS)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .bom_length (bom_r),
    .fire       (fire),
    .data_byte  (data_r),
    .has_byte   (has_r),
    .last_item  (last_r),
    .push_cnt   (push_cnt),
    .push_res   (push_res)
  );

  // The queue parts the scanner from the result channel: a stalled result
  // does not hold up the scanner until the queue runs short of room.
  lei_pkg::result_t head;

  assign pop = rq_stat.not_empty && !out_stall;

  lei_rq u_rq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_cnt (push_cnt),
    .push_res (push_res),
    .pop      (pop),
    .head     (head),
    .status   (rq_stat)
  );

  assign out_valid        = rq_stat.not_empty;
  assign out_result_kind  = head.result_kind;
  assign out_line_offset  = head.line_offset;
  assign out_line_length  = head.line_length;
  assign out_line_end     = head.line_end;
  assign out_row_count    = head.row_count;
  assign out_max_length   = head.max_length;
  assign out_total_bytes  = head.total_bytes;
  assign out_dominant_end = head.dominant_end;
  assign out_last_result  = head.last_result;

endmodule

`default_nettype wire

// ===== rtl/core/lei_scan.sv =====
// Line scanner: per-file state, line detection and result formatting.
`default_nettype none

module lei_scan #(
  parameter int CW = lei_pkg::COUNTER_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic [lei_pkg::BOM_W-1:0]             bom_length,
  input  wire logic                                  fire,
  input  wire logic [7:0]                            data_byte,
  input  wire logic                                  has_byte,
  input  wire logic                                  last_item,
  output logic [lei_pkg::PUSH_W-1:0]                 push_cnt,
  output lei_pkg::result_t [lei_pkg::MAX_RESULTS-1:0] push_res
);

  localparam logic [CW-1:0] CMAX = '1;

  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a,
                                             input logic [CW-1:0] b);
    logic [CW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CW] ? CMAX : s[CW-1:0];
  endfunction

  function automatic logic [CW-1:0] sat_add3(input logic [CW-1:0] a,
                                              input logic [CW-1:0] b,
                                              input logic [CW-1:0] c);
    logic [CW+1:0] s;
    s = {2'b00, a} + {2'b00, b} + {2'b00, c};
    return (s > {2'b00, CMAX}) ? CMAX : s[CW-1:0];
  endfunction

  function automatic logic [CW-1:0] span(input logic [CW-1:0] stop,
                                          input logic [CW-1:0] start);
    return (stop > start) ? (stop - start) : '0;
  endfunction

  function automatic lei_pkg::result_t make_line(input logic [CW-1:0] start,
                                                 input logic [CW-1:0] len,
                                                 input lei_pkg::line_end_t kind);
    lei_pkg::result_t r;
    r             = '0;
    r.result_kind = lei_pkg::KIND_LINE;
    r.line_offset = 32'(64'(start));
    r.line_length = 33'(64'(len));
    r.line_end    = kind;
    return r;
  endfunction

  function automatic lei_pkg::result_t make_error(input lei_pkg::line_end_t kind);
    lei_pkg::result_t r;
    r              = '0;
    r.result_kind  = lei_pkg::KIND_ERROR;
    r.line_end     = kind;
    r.dominant_end = kind;
    r.last_result  = 1'b1;
    return r;
  endfunction

  // File state
  logic [lei_pkg::BOM_W-1:0] skip_r;
  logic [CW-1:0]             pos_r;
  logic [CW-1:0]             ls_r;
  logic                      pc_r;
  logic [CW-1:0]             lf_r;
  logic [CW-1:0]             crlf_r;
  logic [CW-1:0]             cr_r;
  logic [CW-1:0]             longest_r;
  logic [CW-1:0]             sum_r;
  logic [30:0]               lines_r;
  logic                      halted_r;

  logic [lei_pkg::BOM_W-1:0] skip_nxt;
  logic [CW-1:0]             pos_nxt;
  logic [CW-1:0]             ls_nxt;
  logic                      pc_nxt;
  logic [CW-1:0]             lf_nxt;
  logic [CW-1:0]             crlf_nxt;
  logic [CW-1:0]             cr_nxt;
  logic [CW-1:0]             longest_nxt;
  logic [CW-1:0]             sum_nxt;
  logic [30:0]               lines_nxt;
  logic                      halted_nxt;

  // Byte stage
  logic                take;
  logic                skip_inc;
  logic                is_lf;
  logic                is_cr;
  logic [CW-1:0]       pos_inc;
  logic [CW-1:0]       pos1;
  logic [CW-1:0]       ls1;
  logic                pc1;
  logic                halt1;

  // Line closed by the byte (T) and line closed by the end of file (X)
  logic                  t_v, t_err, t_rec, t_fail;
  lei_pkg::line_end_t    t_kind;
  logic [CW-1:0]         t_stop, t_len, t_len_eff;
  logic                  x_v, x_err, x_rec, x_fail;
  lei_pkg::line_end_t    x_kind;
  logic [CW-1:0]         x_stop, x_len, x_len_eff;
  logic                  s_v;

  logic                  t_lf, t_crlf, t_cr, x_cr;
  logic [CW-1:0]         lf_t, crlf_t, cr_t, cr_s;
  logic [CW-1:0]         longest_t, longest_s;
  logic [CW-1:0]         sum_t, sum_s;
  logic [31:0]           lines_t_w, lines_s_w;
  logic [30:0]           lines_t, lines_s;
  lei_pkg::line_end_t    dom;

  lei_pkg::result_t      res_t_line, res_x_line, res_sum;

  always_comb begin
    is_lf    = (data_byte == lei_pkg::CHAR_LF);
    is_cr    = (data_byte == lei_pkg::CHAR_CR);
    take     = has_byte && !halted_r && (skip_r >= bom_length);
    skip_inc = has_byte && !halted_r && (skip_r < bom_length);
    pos_inc  = (pos_r == CMAX) ? pos_r : pos_r + CW'(1);

    // A byte closes at most one line: the one held open by a pending CR,
    // or the current one when the byte is a LF.
    t_v    = take && (pc_r || is_lf);
    t_kind = pc_r ? (is_lf ? lei_pkg::END_CRLF : lei_pkg::END_CR) : lei_pkg::END_LF;
    t_stop = pc_r ? pos_r - CW'(1) : pos_r;
    t_len  = span(t_stop, ls_r);
    t_err  = 64'(ls_r) > lei_pkg::OFF_LIMIT;
    t_rec  = t_v && !t_err;
    t_fail = t_v && t_err;

    pos1 = take ? pos_inc : pos_r;
    pc1  = take ? is_cr : pc_r;
    if (!take) begin
      ls1 = ls_r;
    end else if (is_lf) begin
      ls1 = pos_inc;
    end else if (pc_r) begin
      ls1 = pos_r;
    end else begin
      ls1 = ls_r;
    end
    halt1 = halted_r || t_fail;

    // At the end of file a pending CR is a lone CR; otherwise an open
    // line with bytes in it is closed without a terminator.
    x_v    = last_item && !halt1 && (pc1 || (pos1 > ls1));
    x_kind = pc1 ? lei_pkg::END_CR : lei_pkg::END_NONE;
    x_stop = pc1 ? pos1 - CW'(1) : pos1;
    x_len  = span(x_stop, ls1);
    x_err  = 64'(ls1) > lei_pkg::OFF_LIMIT;
    x_rec  = x_v && !x_err;
    x_fail = x_v && x_err;
    s_v    = last_item && !halt1 && !x_fail;

    t_len_eff = t_rec ? t_len : '0;
    x_len_eff = x_rec ? x_len : '0;
    t_lf      = t_rec && (t_kind == lei_pkg::END_LF);
    t_crlf    = t_rec && (t_kind == lei_pkg::END_CRLF);
    t_cr      = t_rec && (t_kind == lei_pkg::END_CR);
    x_cr      = x_rec && (x_kind == lei_pkg::END_CR);

    lf_t      = sat_add(lf_r, CW'(t_lf));
    crlf_t    = sat_add(crlf_r, CW'(t_crlf));
    cr_t      = sat_add(cr_r, CW'(t_cr));
    cr_s      = sat_add(cr_r, CW'({1'b0, t_cr} + {1'b0, x_cr}));
    longest_t = (t_len_eff > longest_r) ? t_len_eff : longest_r;
    longest_s = (x_len_eff > longest_t) ? x_len_eff : longest_t;
    sum_t     = sat_add(sum_r, t_len_eff);
    sum_s     = sat_add3(sum_r, t_len_eff, x_len_eff);
    lines_t_w = {1'b0, lines_r} + 32'(t_rec);
    lines_s_w = {1'b0, lines_r} + 32'(t_rec) + 32'(x_rec);
    lines_t   = (lines_t_w > {1'b0, lei_pkg::ROW_MAX}) ? lei_pkg::ROW_MAX : lines_t_w[30:0];
    lines_s   = (lines_s_w > {1'b0, lei_pkg::ROW_MAX}) ? lei_pkg::ROW_MAX : lines_s_w[30:0];

    if (crlf_t > lf_t && crlf_t > cr_s) begin
      dom = lei_pkg::END_CRLF;
    end else if (cr_s > lf_t && cr_s > crlf_t) begin
      dom = lei_pkg::END_CR;
    end else begin
      dom = lei_pkg::END_LF;
    end

    res_t_line = t_err ? make_error(t_kind) : make_line(ls_r, t_len, t_kind);
    res_x_line = x_err ? make_error(x_kind) : make_line(ls1, x_len, x_kind);
    res_sum              = '0;
    res_sum.result_kind  = lei_pkg::KIND_SUMMARY;
    res_sum.row_count    = lines_s;
    res_sum.max_length   = 33'(64'(longest_s));
    res_sum.total_bytes  = 33'(64'(sum_s));
    res_sum.dominant_end = dom;
    res_sum.last_result  = 1'b1;

    // Pack the results in order with no gaps.
    push_res[0] = t_v ? res_t_line : (x_v ? res_x_line : res_sum);
    push_res[1] = t_v ? (x_v ? res_x_line : res_sum) : res_sum;
    push_res[2] = res_sum;
    push_cnt    = fire ? (lei_pkg::PUSH_W'(t_v) + lei_pkg::PUSH_W'(x_v)
                          + lei_pkg::PUSH_W'(s_v)) : '0;

    if (last_item) begin
      skip_nxt    = '0;
      pos_nxt     = '0;
      ls_nxt      = '0;
      pc_nxt      = 1'b0;
      lf_nxt      = '0;
      crlf_nxt    = '0;
      cr_nxt      = '0;
      longest_nxt = '0;
      sum_nxt     = '0;
      lines_nxt   = '0;
      halted_nxt  = 1'b0;
    end else begin
      skip_nxt    = skip_inc ? skip_r + lei_pkg::BOM_W'(1) : skip_r;
      pos_nxt     = pos1;
      ls_nxt      = ls1;
      pc_nxt      = pc1;
      lf_nxt      = lf_t;
      crlf_nxt    = crlf_t;
      cr_nxt      = cr_t;
      longest_nxt = longest_t;
      sum_nxt     = sum_t;
      lines_nxt   = lines_t;
      halted_nxt  = halt1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r    <= '0;
      pos_r     <= '0;
      ls_r      <= '0;
      pc_r      <= 1'b0;
      lf_r      <= '0;
      crlf_r    <= '0;
      cr_r      <= '0;
      longest_r <= '0;
      sum_r     <= '0;
      lines_r   <= '0;
      halted_r  <= 1'b0;
    end else if (fire) begin
      skip_r    <= skip_nxt;
      pos_r     <= pos_nxt;
      ls_r      <= ls_nxt;
      pc_r      <= pc_nxt;
      lf_r      <= lf_nxt;
      crlf_r    <= crlf_nxt;
      cr_r      <= cr_nxt;
      longest_r <= longest_nxt;
      sum_r     <= sum_nxt;
      lines_r   <= lines_nxt;
      halted_r  <= halted_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/lei_rq.sv =====
// Result queue: takes up to three results at once and hands them out one a cycle while pop is high.
`default_nettype none

module lei_rq (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic [lei_pkg::PUSH_W-1:0]             push_cnt,
  input  wire lei_pkg::result_t [lei_pkg::MAX_RESULTS-1:0] push_res,
  input  wire logic                                   pop,
  output lei_pkg::result_t                            head,
  output lei_pkg::rq_status_t                         status
);

  localparam int CNT_W = $clog2(lei_pkg::RQ_DEPTH + 1);
  localparam int IDX_W = $clog2(lei_pkg::MAX_RESULTS);

  lei_pkg::result_t slot_r   [lei_pkg::RQ_DEPTH];
  lei_pkg::result_t slot_nxt [lei_pkg::RQ_DEPTH];
  lei_pkg::result_t slot_up  [lei_pkg::RQ_DEPTH];
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [CNT_W-1:0] base;
  logic [CNT_W-1:0] off [lei_pkg::RQ_DEPTH];

  always_comb begin
    base = cnt_r - CNT_W'(pop);
    for (int i = 0; i < lei_pkg::RQ_DEPTH - 1; i++) begin
      slot_up[i] = slot_r[i + 1];
    end
    slot_up[lei_pkg::RQ_DEPTH - 1] = slot_r[lei_pkg::RQ_DEPTH - 1];

    for (int i = 0; i < lei_pkg::RQ_DEPTH; i++) begin
      off[i] = CNT_W'(i) - base;
      if (CNT_W'(i) < base) begin
        slot_nxt[i] = pop ? slot_up[i] : slot_r[i];
      end else if (off[i] < CNT_W'(push_cnt)) begin
        slot_nxt[i] = push_res[off[i][IDX_W-1:0]];
      end else begin
        slot_nxt[i] = slot_r[i];
      end
    end

    cnt_nxt          = base + CNT_W'(push_cnt);
    head             = slot_r[0];
    status.not_empty = (cnt_r != '0);
    status.room      = (base <= CNT_W'(lei_pkg::RQ_DEPTH - lei_pkg::MAX_RESULTS));
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < lei_pkg::RQ_DEPTH; i++) begin
      slot_r[i] <= slot_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== verif/tb_line_ending_indexer.sv =====
// Testbench for the line ending indexer: directed and random byte streams checked by a predictor.
`timescale 1ns / 1ps

module tb_line_ending_indexer;
  import lei_pkg::*;

  // Register address of the byte-order-mark length.
  localparam logic [2:0] BOM_ADDR = 3'd0;

  // A run that accepts nothing on either channel for this many cycles has hung.
  localparam int QUIET_LIMIT   = 4000;
  // Cycles the receiver holds off in the back-pressure phase.
  localparam int HOLD_CYCLES   = 200;
  // Cycles allowed after the last result before the block counts as idle.
  localparam int SETTLE_CYCLES = 8;

  localparam logic [32:0] CNT_MAX     = '1;
  localparam logic [32:0] START_LIMIT = OFF_LIMIT[32:0];

  logic        clk;
  logic        rst_n;

  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_has_byte;
  logic        in_last_item;

  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_result_kind;
  logic [31:0] out_line_offset;
  logic [32:0] out_line_length;
  logic [1:0]  out_line_end;
  logic [30:0] out_row_count;
  logic [32:0] out_max_length;
  logic [32:0] out_total_bytes;
  logic [1:0]  out_dominant_end;
  logic        out_last_result;

  line_ending_indexer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_has_byte      (in_has_byte),
    .in_last_item     (in_last_item),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_line_offset  (out_line_offset),
    .out_line_length  (out_line_length),
    .out_line_end     (out_line_end),
    .out_row_count    (out_row_count),
    .out_max_length   (out_max_length),
    .out_total_bytes  (out_total_bytes),
    .out_dominant_end (out_dominant_end),
    .out_last_result  (out_last_result)
  );

  // One row of the directed script. A row may first rewrite the mark length
  // (bom_wr >= 0). Where pin is set, the first result of the row is typed in
  // by hand and replaces the predicted one, so the DUT is compared against a
  // value that does not come from the predictor at all.
  typedef struct {
    int         bom_wr;
    logic [7:0] data;
    bit         has;
    bit         last;
    bit         pin;
    result_t    rec;
  } script_row_t;

  int      errors;
  int      gap_pct;     // chance in 100 that the sender idles before a transaction
  int      stall_pct;   // chance in 100 that the receiver stalls in a cycle
  bit      long_hold;   // asks the receiver for one long hold-off

  // Side information that travels with the payload on the input channel.
  bit      pin_now;
  result_t pin_rec;

  // Predicted index records, oldest first.
  result_t index_q[$];

  // Predictor state, a copy of what the block keeps for the current file.
  logic [2:0]  bom_cfg;
  logic [2:0]  skipped;
  logic [32:0] pos;
  logic [32:0] start_pos;
  bit          cr_held;
  logic [32:0] n_lf;
  logic [32:0] n_crlf;
  logic [32:0] n_cr;
  logic [32:0] longest_len;
  logic [32:0] byte_sum;
  logic [30:0] rows;
  bit          stopped;

  // ------------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------------

  function automatic logic [32:0] bump(logic [32:0] v);
    return (v == CNT_MAX) ? v : v + 33'd1;
  endfunction

  // Everything but the mark length goes back to zero at the end of a file.
  function automatic void clear_file();
    skipped     = '0;
    pos         = '0;
    start_pos   = '0;
    cr_held     = 1'b0;
    n_lf        = '0;
    n_crlf      = '0;
    n_cr        = '0;
    longest_len = '0;
    byte_sum    = '0;
    rows        = '0;
    stopped     = 1'b0;
  endfunction

  // Closes the line from start_pos up to, not including, stop. A line that
  // starts past the offset limit turns into an error and halts the file.
  function automatic void close_line(line_end_t kind, logic [32:0] stop);
    logic [32:0] len;
    result_t     r;
    len = (stop > start_pos) ? stop - start_pos : '0;
    r = '0;
    r.line_end = kind;
    if (start_pos > START_LIMIT) begin
      r.result_kind  = KIND_ERROR;
      r.dominant_end = kind;
      r.last_result  = 1'b1;
      index_q.push_back(r);
      stopped = 1'b1;
      return;
    end
    r.result_kind = KIND_LINE;
    r.line_offset = start_pos[31:0];
    r.line_length = len;
    index_q.push_back(r);
    if (rows != ROW_MAX) rows = rows + 31'd1;
    if (len > longest_len) longest_len = len;
    byte_sum = (CNT_MAX - byte_sum < len) ? CNT_MAX : byte_sum + len;
    case (kind)
      END_LF:   n_lf   = bump(n_lf);
      END_CRLF: n_crlf = bump(n_crlf);
      END_CR:   n_cr   = bump(n_cr);
      default:  ;
    endcase
  endfunction

  // A CR is held until the next byte tells whether it pairs with an LF.
  function automatic void take_byte(logic [7:0] b);
    logic [32:0] p;
    p = pos;
    if (cr_held) begin
      cr_held = 1'b0;
      if (b == CHAR_LF) begin
        close_line(END_CRLF, p - 33'd1);
        pos       = bump(p);
        start_pos = pos;
        return;
      end
      close_line(END_CR, p - 33'd1);
      start_pos = p;
      if (stopped) return;
    end
    pos = bump(p);
    if (b == CHAR_LF) begin
      close_line(END_LF, p);
      start_pos = pos;
    end else if (b == CHAR_CR) begin
      cr_held = 1'b1;
    end
  endfunction

  // Works out the records caused by one accepted transaction.
  function automatic void index_item(logic [7:0] b, logic has, logic last);
    result_t   r;
    line_end_t dom;
    if (has && !stopped) begin
      if (skipped < bom_cfg) skipped = skipped + 3'd1;
      else take_byte(b);
    end
    if (!last) return;
    // A CR right before the end of the file is a lone CR.
    if (!stopped && cr_held) begin
      cr_held = 1'b0;
      close_line(END_CR, pos - 33'd1);
      start_pos = pos;
    end
    if (!stopped && pos > start_pos) close_line(END_NONE, pos);
    if (!stopped) begin
      dom = END_LF;
      if (n_crlf > n_lf && n_crlf > n_cr) dom = END_CRLF;
      else if (n_cr > n_lf && n_cr > n_crlf) dom = END_CR;
      r = '0;
      r.result_kind  = KIND_SUMMARY;
      r.row_count    = rows;
      r.max_length   = longest_len;
      r.total_bytes  = byte_sum;
      r.dominant_end = dom;
      r.last_result  = 1'b1;
      index_q.push_back(r);
    end
    clear_file();
  endfunction

  // ------------------------------------------------------------------------
  // Clock, reset and the receiver
  // ------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The receiver stalls at random; on request it holds off for a long
  // stretch so that the result queue fills and the input backs up.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end
      out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end
  end

  // ------------------------------------------------------------------------
  // Monitor and scoreboard
  // ------------------------------------------------------------------------

  function automatic void cmp_field(string name, logic [32:0] want, logic [32:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected 'h%0h, actual 'h%0h", $time, name, want, got);
    end
  endfunction

  // Both channels are sampled at the rising edge, before the DUT's own
  // updates at that edge take effect. The input side is handled first so a
  // prediction is always queued before its result can be seen.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    int      n0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        n0 = index_q.size();
        index_item(in_data_byte, in_has_byte, in_last_item);
        if (pin_now) begin
          if (index_q.size() == n0) begin
            errors++;
            $display("%0t: hand-typed record has no predicted counterpart", $time);
          end else begin
            index_q[n0] = pin_rec;
          end
        end
      end
      if (out_valid && !out_stall) begin
        got.result_kind  = result_kind_t'(out_result_kind);
        got.line_offset  = out_line_offset;
        got.line_length  = out_line_length;
        got.line_end     = line_end_t'(out_line_end);
        got.row_count    = out_row_count;
        got.max_length   = out_max_length;
        got.total_bytes  = out_total_bytes;
        got.dominant_end = line_end_t'(out_dominant_end);
        got.last_result  = out_last_result;
        if (index_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected record, kind %0d offset 'h%0h", $time,
                   out_result_kind, out_line_offset);
        end else begin
          want = index_q.pop_front();
          cmp_field("result_kind", want.result_kind, got.result_kind);
          cmp_field("line_offset", want.line_offset, got.line_offset);
          cmp_field("line_length", want.line_length, got.line_length);
          cmp_field("line_end", want.line_end, got.line_end);
          cmp_field("row_count", want.row_count, got.row_count);
          cmp_field("max_length", want.max_length, got.max_length);
          cmp_field("total_bytes", want.total_bytes, got.total_bytes);
          cmp_field("dominant_end", want.dominant_end, got.dominant_end);
          cmp_field("last_result", want.last_result, got.last_result);
        end
      end
    end
  end

  // Watchdog: a long run of cycles with no transaction on either side means
  // the block has hung.
  always @(posedge clk) begin
    int quiet;
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // ------------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------------

  // Offers one transaction and returns at the edge that accepts it. Valid
  // stays high afterwards, so back-to-back calls stream without a bubble while gap_pct is zero.
  task automatic offer(input logic [7:0] b, input bit has, input bit last,
                       input bit pin, input result_t rec);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_has_byte  <= has;
    in_last_item <= last;
    pin_now      <= pin;
    pin_rec      <= rec;
    do @(posedge clk); while (in_stall);
  endtask

  // The sender drops out until every predicted record has come back, then
  // waits SETTLE_CYCLES more for a transaction that produced nothing.
  task automatic settle();
    in_valid <= 1'b0;
    while (index_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the mark length and reads it back. The predictor takes the new
  // value at the edge that completes the write.
  task automatic write_bom(input logic [2:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= BOM_ADDR;
    cfg_pwdata  <= 32'(val);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    bom_cfg = val;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== 32'(val)) begin
      errors++;
      $display("%0t: bom_length readback mismatch, expected 'h%0h, actual 'h%0h",
               $time, val, cfg_prdata);
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Random file contents. Terminators are made common so that lines stay
  // short, a byte after a CR is often an LF, and a few transactions carry no
  // byte or end the file.
  task automatic random_file_bytes(input int count, input int brk_pct);
    logic [7:0] b;
    bit         has;
    bit         last;
    bit         after_cr;
    after_cr = 1'b0;
    repeat (count) begin
      b = 8'($urandom_range(255));
      if (after_cr && $urandom_range(1) == 1) b = CHAR_LF;
      else if ($urandom_range(99) < brk_pct) b = ($urandom_range(1) == 1) ? CHAR_LF : CHAR_CR;
      has      = $urandom_range(99) >= 5;
      last     = $urandom_range(99) < 4;
      after_cr = has && (b == CHAR_CR);
      offer(b, has, last, 1'b0, '0);
    end
  endtask

  function automatic result_t mk(result_kind_t kind, logic [31:0] off, logic [32:0] len,
                                 line_end_t lend, logic [30:0] nrows, line_end_t dom,
                                 logic last);
    result_t r;
    r = '0;
    r.result_kind  = kind;
    r.line_offset  = off;
    r.line_length  = len;
    r.line_end     = lend;
    r.row_count    = nrows;
    r.dominant_end = dom;
    r.last_result  = last;
    return r;
  endfunction

  function automatic script_row_t row(int bom_wr, logic [7:0] data, bit has, bit last,
                                      bit pin, result_t rec);
    script_row_t s;
    s.bom_wr = bom_wr;
    s.data   = data;
    s.has    = has;
    s.last   = last;
    s.pin    = pin;
    s.rec    = rec;
    return s;
  endfunction

  initial begin
    script_row_t script[$];
    result_t     empty_sum;
    int          phase_gap[4];
    int          phase_stall[4];
    logic [2:0]  phase_bom[4];

    rst_n        <= 1'b0;
    cfg_psel     <= 1'b0;
    cfg_penable  <= 1'b0;
    cfg_pwrite   <= 1'b0;
    cfg_paddr    <= '0;
    cfg_pwdata   <= '0;
    in_valid     <= 1'b0;
    in_data_byte <= '0;
    in_has_byte  <= 1'b0;
    in_last_item <= 1'b0;
    pin_now      <= 1'b0;
    pin_rec      <= '0;
    errors       = 0;
    gap_pct      = 0;
    stall_pct    = 0;
    long_hold    = 1'b0;
    bom_cfg      = '0;
    clear_file();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed script. The mark length starts at its reset value of zero.
    empty_sum = mk(KIND_SUMMARY, 0, 0, END_LF, 0, END_LF, 1'b1);
    // An empty file right after reset gives a zero-row summary.
    script.push_back(row(-1, 8'h00, 1'b0, 1'b1, 1'b1, empty_sum));
    // "a" LF, then CR LF, then a lone CR followed by an ordinary byte.
    script.push_back(row(-1, "a", 1'b1, 1'b0, 1'b0, '0));
    script.push_back(row(-1, CHAR_LF, 1'b1, 1'b0, 1'b1,
                         mk(KIND_LINE, 0, 1, END_LF, 0, END_LF, 1'b0)));
    script.push_back(row(-1, CHAR_CR, 1'b1, 1'b0, 1'b0, '0));
    script.push_back(row(-1, CHAR_LF, 1'b1, 1'b0, 1'b1,
                         mk(KIND_LINE, 2, 0, END_CRLF, 0, END_LF, 1'b0)));
    script.push_back(row(-1, CHAR_CR, 1'b1, 1'b0, 1'b0, '0));
    script.push_back(row(-1, "x", 1'b1, 1'b0, 1'b1,
                         mk(KIND_LINE, 4, 0, END_CR, 0, END_LF, 1'b0)));
    // Byte extremes inside a line, then a CR on the end mark: a lone CR.
    script.push_back(row(-1, 8'hFF, 1'b1, 1'b0, 1'b0, '0));
    script.push_back(row(-1, 8'h00, 1'b1, 1'b0, 1'b0, '0));
    script.push_back(row(-1, CHAR_CR, 1'b1, 1'b1, 1'b0, '0));
    // A transaction with neither byte nor end mark does nothing.
    script.push_back(row(-1, 8'h55, 1'b0, 1'b0, 1'b0, '0));
    // A last line with no terminator.
    script.push_back(row(-1, "z", 1'b1, 1'b1, 1'b1,
                         mk(KIND_LINE, 0, 1, END_NONE, 0, END_LF, 1'b0)));
    // A file that is a single CR: lone CR dominates.
    script.push_back(row(-1, CHAR_CR, 1'b1, 1'b1, 1'b0, '0));
    // Four-byte mark, skipped before offset zero.
    script.push_back(row(4, 8'hEF, 1'b1, 1'b0, 1'b0, '0));
    script.push_back(row(-1, 8'hBB, 1'b1, 1'b0, 1'b0, '0));
    script.push_back(row(-1, 8'hBF, 1'b1, 1'b0, 1'b0, '0));
    script.push_back(row(-1, CHAR_LF, 1'b1, 1'b0, 1'b0, '0));
    script.push_back(row(-1, CHAR_CR, 1'b1, 1'b0, 1'b0, '0));
    script.push_back(row(-1, CHAR_LF, 1'b1, 1'b0, 1'b1,
                         mk(KIND_LINE, 0, 0, END_CRLF, 0, END_LF, 1'b0)));
    script.push_back(row(-1, "q", 1'b1, 1'b1, 1'b0, '0));
    // A file no longer than the mark is empty.
    script.push_back(row(-1, "a", 1'b1, 1'b1, 1'b1, empty_sum));
    // Largest mark length, with an empty file.
    script.push_back(row(7, 8'h00, 1'b0, 1'b1, 1'b1, empty_sum));

    foreach (script[i]) begin
      if (script[i].bom_wr >= 0) begin
        settle();
        write_bom(3'(script[i].bom_wr));
      end
      offer(script[i].data, script[i].has, script[i].last, script[i].pin, script[i].rec);
    end

    // Random phases: no idling, sender idling, receiver stalling, both.
    // Files run across phase boundaries, so a new mark length sometimes
    // lands while a file is still being skipped.
    phase_gap   = '{0, 62, 0, 16};
    phase_stall = '{0, 0, 62, 16};
    phase_bom   = '{3'd1, 3'd3, 3'd7, 3'd2};
    for (int ph = 0; ph < 4; ph++) begin
      settle();
      write_bom(phase_bom[ph]);
      gap_pct   = phase_gap[ph];
      stall_pct = phase_stall[ph];
      random_file_bytes(70, 20);
    end

    // Back-pressure: the receiver holds off while the sender keeps offering
    // line-heavy text until the input stalls; then everything drains.
    settle();
    write_bom(3'd0);
    gap_pct   = 0;
    stall_pct = 0;
    long_hold = 1'b1;
    random_file_bytes(40, 45);
    offer(8'h00, 1'b0, 1'b1, 1'b0, '0);

    settle();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/lei_pkg.sv
rtl/core/lei_scan.sv
rtl/core/lei_rq.sv
rtl/core/line_ending_indexer.sv
verif/tb_line_ending_indexer.sv
